### rtl/aes_pkg.sv
`timescale 1ns / 1ps
package aes_pkg;

  localparam int unsigned BlockW = 128;
  localparam int unsigned HalfW  = 64;
  localparam int unsigned Rounds = 10;

  typedef logic [BlockW-1:0] block_t;
  typedef logic [Rounds:0][BlockW-1:0] round_keys_t;

  typedef enum logic {
    REG_KEY_HIGH = 1'b0,
    REG_KEY_LOW  = 1'b1
  } reg_idx_e;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [7:0] RCON [Rounds] = '{
    8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'h1b,8'h36
  };

  function automatic logic [7:0] xtime(input logic [7:0] a);
    xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] get_byte(input block_t s, input int unsigned n);
    get_byte = s[BlockW-1-8*n -: 8];
  endfunction

  function automatic block_t sub_shift(input block_t s);
    block_t t;
    t = '0;
    for (int unsigned c = 0; c < 4; c++) begin
      for (int unsigned r = 0; r < 4; r++) begin
        t[BlockW-1-8*(r+4*c) -: 8] = SBOX[get_byte(s, r + 4*((c + r) % 4))];
      end
    end
    sub_shift = t;
  endfunction

  function automatic block_t mix_cols(input block_t s);
    block_t t;
    logic [7:0] a0, a1, a2, a3, all;
    t = '0;
    for (int unsigned c = 0; c < 4; c++) begin
      a0  = get_byte(s, 4*c);
      a1  = get_byte(s, 4*c + 1);
      a2  = get_byte(s, 4*c + 2);
      a3  = get_byte(s, 4*c + 3);
      all = a0 ^ a1 ^ a2 ^ a3;
      t[BlockW-1-32*c -: 32] = {a0 ^ all ^ xtime(a0 ^ a1), a1 ^ all ^ xtime(a1 ^ a2),
                                a2 ^ all ^ xtime(a2 ^ a3), a3 ^ all ^ xtime(a3 ^ a0)};
    end
    mix_cols = t;
  endfunction

endpackage

### rtl/aes_key_exp.sv
`timescale 1ns / 1ps
module aes_key_exp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  aes_pkg::reg_idx_e   cfg_idx_i,
  input  logic [63:0]         cfg_wdata_i,
  output aes_pkg::round_keys_t round_keys_o
);
  import aes_pkg::*;

  logic [HalfW-1:0] key_high_q, key_low_q;
  logic [31:0] w [4*(Rounds+1)];
  logic [31:0] rot;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_high_q <= '0;
      key_low_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_KEY_HIGH: key_high_q <= cfg_wdata_i;
        REG_KEY_LOW:  key_low_q  <= cfg_wdata_i;
        default:      key_low_q  <= key_low_q;
      endcase
    end
  end

  always_comb begin
    rot = '0;
    w[0] = key_high_q[63:32];
    w[1] = key_high_q[31:0];
    w[2] = key_low_q[63:32];
    w[3] = key_low_q[31:0];
    for (int unsigned i = 4; i < 4*(Rounds+1); i++) begin
      if (i % 4 == 0) begin
        rot = {SBOX[w[i-1][23:16]] ^ RCON[i/4-1], SBOX[w[i-1][15:8]],
               SBOX[w[i-1][7:0]], SBOX[w[i-1][31:24]]};
      end else begin
        rot = w[i-1];
      end
      w[i] = w[i-4] ^ rot;
    end
    for (int unsigned k = 0; k <= Rounds; k++) begin
      round_keys_o[k] = {w[4*k], w[4*k+1], w[4*k+2], w[4*k+3]};
    end
  end

endmodule

### rtl/aes_cipher_core.sv
`timescale 1ns / 1ps
module aes_cipher_core (
  input  aes_pkg::block_t      state_i,
  input  aes_pkg::round_keys_t round_keys_i,
  output aes_pkg::block_t      state_o
);
  import aes_pkg::*;

  block_t st [Rounds+1];

  assign st[0] = state_i ^ round_keys_i[0];

  for (genvar r = 1; r < Rounds; r++) begin : g_round
    assign st[r] = mix_cols(sub_shift(st[r-1])) ^ round_keys_i[r];
  end

  assign st[Rounds] = sub_shift(st[Rounds-1]) ^ round_keys_i[Rounds];
  assign state_o    = st[Rounds];

endmodule

### rtl/aes128_block_encrypt.sv
`timescale 1ns / 1ps
// An accepted item is held in the input register, and its result then in the result register.
// Throughput: one item per cycle unless m_axis_tready stalls; the full 10-round cipher
// and key schedule sit between the input register and the result register.
// Reset: asynchronous active-low; clears both valid flags and the key to zero.
module aes128_block_encrypt (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic         cfg_idx_i,
  input  logic [63:0]  cfg_wdata_i,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [127:0] s_axis_tdata,  // plain_high, plain_low
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [127:0] m_axis_tdata   // cipher_high, cipher_low
);
  import aes_pkg::*;

  round_keys_t rkeys;
  block_t      in_d, in_q, res_d, res_q;
  logic        in_vld_q, out_vld_q, out_adv, in_adv;

  aes_key_exp u_key (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i    (reg_idx_e'(cfg_idx_i)),
    .cfg_wdata_i,
    .round_keys_o (rkeys)
  );

  aes_cipher_core u_core (
    .state_i      (in_q),
    .round_keys_i (rkeys),
    .state_o      (res_d)
  );

  assign out_adv       = !out_vld_q || m_axis_tready;
  assign in_adv        = !in_vld_q || out_adv;
  assign s_axis_tready = in_adv;
  assign in_d          = {s_axis_tdata[63:0], s_axis_tdata[127:64]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_adv)  in_vld_q  <= s_axis_tvalid;
      if (out_adv) out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_adv && s_axis_tvalid) in_q <= in_d;
    if (out_adv && in_vld_q)     res_q <= res_d;
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {res_q[63:0], res_q[127:64]};

  a_accept_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> in_vld_q)
    else $error("accepted item not held in input register");

  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output");

  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(in_vld_q))
    else $error("result appeared without an item in flight");

endmodule
